[rtl/swt_pkg.sv]
`timescale 1ns / 1ps

package swt_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned CountW = 34;
	localparam int unsigned PosW   = 33;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_DEFAULT = 3'd1,
		PH_LOW     = 3'd2,
		PH_HIGH    = 3'd3,
		PH_ENTRIES = 3'd4,
		PH_NPAIRS  = 3'd5,
		PH_MATCH   = 3'd6,
		PH_OFFSET  = 3'd7
	} phase_t;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_WORD  = 1'b1
	} action_t;

	typedef enum logic {
		KIND_TABLE  = 1'b0,
		KIND_LOOKUP = 1'b1
	} kind_t;

	typedef struct packed {
		logic [WordW-1:0] target_address;
		logic             took_case;
	} result_t;

endpackage

[rtl/swt_core.sv]
`timescale 1ns / 1ps

module swt_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic                          action,
	input  logic                          kind,
	input  logic [swt_pkg::WordW-1:0]     opcode_address,
	input  logic [swt_pkg::WordW-1:0]     key,
	input  logic [swt_pkg::WordW-1:0]     word,
	output logic                          res_valid,
	output swt_pkg::result_t              res
);

	swt_pkg::phase_t                 phase_q, phase_d;
	logic                            is_lookup_q, is_lookup_d;
	logic [swt_pkg::WordW-1:0]       base_address_q, base_address_d;
	logic [swt_pkg::WordW-1:0]       search_key_q, search_key_d;
	logic [swt_pkg::WordW-1:0]       default_offset_q, default_offset_d;
	logic [swt_pkg::WordW-1:0]       low_bound_q, low_bound_d;
	logic [swt_pkg::CountW-1:0]      words_left_q, words_left_d;
	logic [swt_pkg::PosW-1:0]        entry_position_q, entry_position_d;
	logic [swt_pkg::PosW-1:0]        hit_pos_q, hit_pos_d;
	logic [swt_pkg::WordW-1:0]       chosen_offset_q, chosen_offset_d;
	logic                            decided_q, decided_d;
	logic                            found_q, found_d;
	logic [swt_pkg::WordW-1:0]       pair_match_q, pair_match_d;

	logic signed [swt_pkg::WordW-1:0] k_s, lo_s, hi_s, w_s, m_s;
	logic [swt_pkg::CountW-1:0]       span;
	logic [swt_pkg::PosW-1:0]         diff;
	logic                             done;

	assign k_s  = $signed(search_key_q);
	assign lo_s = $signed(low_bound_q);
	assign w_s  = $signed(word);
	assign hi_s = w_s;
	assign m_s  = $signed(pair_match_q);
	assign span = swt_pkg::CountW'({{2{word[31]}}, word})
		- swt_pkg::CountW'({{2{low_bound_q[31]}}, low_bound_q})
		+ swt_pkg::CountW'(1);
	assign diff = {search_key_q[31], search_key_q} - {low_bound_q[31], low_bound_q};

	always_comb begin
		phase_d          = phase_q;
		is_lookup_d      = is_lookup_q;
		base_address_d   = base_address_q;
		search_key_d     = search_key_q;
		default_offset_d = default_offset_q;
		low_bound_d      = low_bound_q;
		words_left_d     = words_left_q;
		entry_position_d = entry_position_q;
		hit_pos_d        = hit_pos_q;
		chosen_offset_d  = chosen_offset_q;
		decided_d        = decided_q;
		found_d          = found_q;
		pair_match_d     = pair_match_q;
		done             = 1'b0;
		if (fire) begin
			if (action == swt_pkg::ACT_START) begin
				is_lookup_d     = kind;
				base_address_d  = opcode_address;
				search_key_d    = key;
				decided_d       = 1'b0;
				found_d         = 1'b0;
				chosen_offset_d = '0;
				phase_d         = swt_pkg::PH_DEFAULT;
			end else begin
				unique case (phase_q)
					swt_pkg::PH_IDLE: begin
					end
					swt_pkg::PH_DEFAULT: begin
						default_offset_d = word;
						phase_d = (is_lookup_q == swt_pkg::KIND_LOOKUP) ?
							swt_pkg::PH_NPAIRS : swt_pkg::PH_LOW;
					end
					swt_pkg::PH_LOW: begin
						low_bound_d = word;
						phase_d     = swt_pkg::PH_HIGH;
					end
					swt_pkg::PH_HIGH: begin
						found_d = 1'b0;
						if (hi_s < lo_s) begin
							done = 1'b1;
						end else begin
							words_left_d     = span;
							entry_position_d = '0;
							hit_pos_d        = diff;
							decided_d        = !((k_s >= lo_s) && (k_s <= hi_s));
							phase_d          = swt_pkg::PH_ENTRIES;
						end
					end
					swt_pkg::PH_ENTRIES: begin
						if (!decided_q && (entry_position_q == hit_pos_q)) begin
							chosen_offset_d = word;
							decided_d       = 1'b1;
							found_d         = 1'b1;
						end
						entry_position_d = entry_position_q + swt_pkg::PosW'(1);
						words_left_d     = words_left_q - swt_pkg::CountW'(1);
						done             = (words_left_q == swt_pkg::CountW'(1));
					end
					swt_pkg::PH_NPAIRS: begin
						found_d = 1'b0;
						if (word == '0) begin
							done = 1'b1;
						end else begin
							words_left_d = {1'b0, word, 1'b0};
							decided_d    = 1'b0;
							phase_d      = swt_pkg::PH_MATCH;
						end
					end
					swt_pkg::PH_MATCH: begin
						pair_match_d = word;
						words_left_d = words_left_q - swt_pkg::CountW'(1);
						phase_d      = swt_pkg::PH_OFFSET;
					end
					swt_pkg::PH_OFFSET: begin
						if (!decided_q) begin
							if (m_s == k_s) begin
								chosen_offset_d = word;
								found_d         = 1'b1;
								decided_d       = 1'b1;
							end else if (m_s > k_s) begin
								found_d   = 1'b0;
								decided_d = 1'b1;
							end
						end
						words_left_d = words_left_q - swt_pkg::CountW'(1);
						done         = (words_left_q == swt_pkg::CountW'(1));
						phase_d      = swt_pkg::PH_MATCH;
					end
					default: begin
					end
				endcase
				if (done) begin
					phase_d = swt_pkg::PH_IDLE;
				end
			end
		end
	end

	always_comb begin
		res_valid          = done;
		res.took_case      = found_d;
		res.target_address = base_address_q + (found_d ? chosen_offset_d : default_offset_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= swt_pkg::PH_IDLE;
			is_lookup_q      <= 1'b0;
			base_address_q   <= '0;
			search_key_q     <= '0;
			default_offset_q <= '0;
			low_bound_q      <= '0;
			words_left_q     <= '0;
			entry_position_q <= '0;
			hit_pos_q        <= '0;
			chosen_offset_q  <= '0;
			decided_q        <= 1'b0;
			found_q          <= 1'b0;
			pair_match_q     <= '0;
		end else begin
			phase_q          <= phase_d;
			is_lookup_q      <= is_lookup_d;
			base_address_q   <= base_address_d;
			search_key_q     <= search_key_d;
			default_offset_q <= default_offset_d;
			low_bound_q      <= low_bound_d;
			words_left_q     <= words_left_d;
			entry_position_q <= entry_position_d;
			hit_pos_q        <= hit_pos_d;
			chosen_offset_q  <= chosen_offset_d;
			decided_q        <= decided_d;
			found_q          <= found_d;
			pair_match_q     <= pair_match_d;
		end
	end

	a_found_decided: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> decided_q)
		else $error("found without decision");

	a_entries_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == swt_pkg::PH_ENTRIES) |-> (words_left_q != '0))
		else $error("entry phase with no words left");

	a_offset_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == swt_pkg::PH_OFFSET) |-> words_left_q[0])
		else $error("pair count out of step");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (phase_q == swt_pkg::PH_IDLE))
		else $error("not idle after result");

endmodule

[rtl/swt_out.sv]
`timescale 1ns / 1ps

module swt_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  swt_pkg::result_t res,
	output logic             can_take,
	output logic             out_valid,
	input  logic             out_ready,
	output swt_pkg::result_t res_q
);

	logic valid_q;

	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load) begin
			res_q <= res;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> (valid_q && $stable(res_q)))
		else $error("stalled result lost");

endmodule

[rtl/switch_branch_target.sv]
`timescale 1ns / 1ps
// channel  handshake            payload
// in       in_valid/in_ready    action, kind, opcode_address, key, word
// out      out_valid/out_ready  target_address, took_case
//
// One request per cycle while in_ready is high; a word or start updates the switch state in the cycle it is taken.
// The result of the last operand word is registered and shows in the cycle after it is taken.
// Input stalls only while the result register is full and out_ready is low.
// Reset (arst_n low) clears the state to idle and drops any pending result.

module switch_branch_target (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic                      kind,
	input  logic [swt_pkg::WordW-1:0] opcode_address,
	input  logic [swt_pkg::WordW-1:0] key,
	input  logic [swt_pkg::WordW-1:0] word,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [swt_pkg::WordW-1:0] target_address,
	output logic                      took_case
);

	logic             fire;
	logic             res_valid;
	swt_pkg::result_t res;
	swt_pkg::result_t res_q;

	assign fire = in_valid && in_ready;

	swt_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.action         (action),
		.kind           (kind),
		.opcode_address (opcode_address),
		.key            (key),
		.word           (word),
		.res_valid      (res_valid),
		.res            (res)
	);

	swt_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.can_take  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign target_address = res_q.target_address;
	assign took_case      = res_q.took_case;

endmodule

[tb/tb_switch_branch_target.sv]
`timescale 1ns / 1ps

module tb_switch_branch_target;
	import swt_pkg::*;

	localparam int KeyMin = 32'sh8000_0000;
	localparam int KeyMax = 32'sh7fff_ffff;
	localparam int QuietLimit = 2000;
	localparam int HoldCycles = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = 1'b0;
	logic        kind = 1'b0;
	logic [31:0] opcode_address = '0;
	logic [31:0] key = '0;
	logic [31:0] word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] target_address;
	logic        took_case;

	switch_branch_target dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.kind           (kind),
		.opcode_address (opcode_address),
		.key            (key),
		.word           (word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.target_address (target_address),
		.took_case      (took_case)
	);

	always #5 clk = ~clk;

	// switch state tracked alongside the block
	phase_t      sw_phase = PH_IDLE;
	bit          sw_lookup = 1'b0;
	bit [31:0]   sw_base = '0;
	bit [31:0]   sw_key = '0;
	bit [31:0]   sw_dflt = '0;
	bit [31:0]   sw_low = '0;
	bit [33:0]   sw_left = '0;
	bit [32:0]   sw_pos = '0;
	bit [31:0]   sw_chosen = '0;
	bit          sw_decided = 1'b0;
	bit          sw_found = 1'b0;
	bit [31:0]   sw_match = '0;

	result_t     pending_targets[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int items_sent = 0;
	int switches_started = 0;
	int targets_checked = 0;
	int input_stall_cycles = 0;
	int quiet_cycles = 0;
	int mismatches = 0;

	function automatic void close_switch();
		result_t r;
		r.target_address = sw_base + (sw_found ? sw_chosen : sw_dflt);
		r.took_case = sw_found;
		pending_targets.push_back(r);
		sw_phase = PH_IDLE;
	endfunction

	function automatic void switch_step(action_t act, kind_t knd, bit [31:0] addr,
			bit [31:0] kval, bit [31:0] w);
		longint k, lo, hi, m;
		if (act == ACT_START) begin
			sw_lookup = (knd == KIND_LOOKUP);
			sw_base = addr;
			sw_key = kval;
			sw_decided = 1'b0;
			sw_found = 1'b0;
			sw_chosen = '0;
			sw_phase = PH_DEFAULT;
			return;
		end
		k = longint'($signed(sw_key));
		lo = longint'($signed(sw_low));
		case (sw_phase)
			PH_DEFAULT: begin
				sw_dflt = w;
				sw_phase = sw_lookup ? PH_NPAIRS : PH_LOW;
			end
			PH_LOW: begin
				sw_low = w;
				sw_phase = PH_HIGH;
			end
			PH_HIGH: begin
				hi = longint'($signed(w));
				if (hi < lo) begin
					sw_found = 1'b0;
					close_switch();
				end else begin
					sw_left = 34'(hi - lo + 1);
					sw_pos = '0;
					sw_decided = !(k >= lo && k <= hi);
					sw_found = 1'b0;
					sw_phase = PH_ENTRIES;
				end
			end
			PH_ENTRIES: begin
				if (!sw_decided && longint'(sw_pos) == k - lo) begin
					sw_chosen = w;
					sw_decided = 1'b1;
					sw_found = 1'b1;
				end
				sw_pos = sw_pos + 33'd1;
				sw_left = sw_left - 34'd1;
				if (sw_left == 0)
					close_switch();
			end
			PH_NPAIRS: begin
				if (w == 0) begin
					sw_found = 1'b0;
					close_switch();
				end else begin
					sw_left = {1'b0, w, 1'b0};
					sw_decided = 1'b0;
					sw_found = 1'b0;
					sw_phase = PH_MATCH;
				end
			end
			PH_MATCH: begin
				sw_match = w;
				sw_left = sw_left - 34'd1;
				sw_phase = PH_OFFSET;
			end
			PH_OFFSET: begin
				if (!sw_decided) begin
					m = longint'($signed(sw_match));
					if (m == k) begin
						sw_chosen = w;
						sw_found = 1'b1;
						sw_decided = 1'b1;
					end else if (m > k) begin
						sw_found = 1'b0;
						sw_decided = 1'b1;
					end
				end
				sw_left = sw_left - 34'd1;
				if (sw_left == 0)
					close_switch();
				else
					sw_phase = PH_MATCH;
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] exp);
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, exp);
		mismatches++;
	endtask

	task automatic send_item(action_t act, kind_t knd, bit [31:0] addr, bit [31:0] kval,
			bit [31:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		kind <= knd;
		opcode_address <= addr;
		key <= kval;
		word <= w;
		do @(posedge clk); while (!in_ready);
		switch_step(act, knd, addr, kval, w);
		items_sent++;
	endtask

	task automatic send_start(kind_t knd, bit [31:0] addr, bit [31:0] kval);
		switches_started++;
		send_item(ACT_START, knd, addr, kval, $urandom());
	endtask

	task automatic send_word(bit [31:0] w);
		send_item(ACT_WORD, kind_t'($urandom_range(1)), $urandom(), $urandom(), w);
	endtask

	task automatic run_table(bit [31:0] addr, int kval, int lo, int hi, int n);
		send_start(KIND_TABLE, addr, kval);
		send_word($urandom());
		send_word(lo);
		send_word(hi);
		repeat (n) send_word($urandom());
	endtask

	task automatic run_lookup(bit [31:0] addr, int kval, bit [31:0] npairs, int match_vals[$]);
		send_start(KIND_LOOKUP, addr, kval);
		send_word($urandom());
		send_word(npairs);
		foreach (match_vals[i]) begin
			send_word(match_vals[i]);
			send_word($urandom());
		end
	endtask

	task automatic random_switch();
		int pick, size, n;
		longint lo, hi, k;
		int mq[$];
		bit [31:0] addr;
		pick = $urandom_range(99);
		addr = $urandom();
		if (pick < 45) begin
			size = ($urandom_range(9) == 0) ? -int'($urandom_range(3))
				: int'($urandom_range(8, 1));
			case ($urandom_range(3))
				0: lo = KeyMin;
				1: lo = KeyMax;
				default: lo = longint'($signed($urandom()));
			endcase
			if (lo + size - 1 > KeyMax)
				lo = KeyMax - size + 1;
			hi = lo + size - 1;
			if (hi < KeyMin) begin
				lo = KeyMin + 1;
				hi = KeyMin;
			end
			if ($urandom_range(3) == 0)
				k = longint'($signed($urandom()));
			else
				k = lo - 2 + $urandom_range(size + 3);
			run_table(addr, int'(k), int'(lo), int'(hi), (size > 0) ? size : 0);
		end else if (pick < 90) begin
			n = $urandom_range(6);
			repeat (n)
				mq.push_back(($urandom_range(1) == 0) ? int'($urandom_range(20)) - 10
					: int'($urandom()));
			mq.sort();
			if ($urandom_range(9) == 0)
				mq.shuffle();
			if (n > 0 && $urandom_range(2) != 0)
				k = longint'(mq[$urandom_range(n - 1)]) + int'($urandom_range(2)) - 1;
			else
				k = longint'($signed($urandom()));
			run_lookup(addr, int'(k), n, mq);
		end else begin
			case ($urandom_range(2))
				0: repeat ($urandom_range(3, 1)) send_word($urandom());
				1: run_table(addr, $urandom(), KeyMin, KeyMax, $urandom_range(5));
				default: begin
					repeat ($urandom_range(2)) mq.push_back($urandom());
					run_lookup(addr, $urandom(), 32'hffff_ffff, mq);
				end
			endcase
		end
	endtask

	task automatic test_table_directed();
		run_table(32'h0000_0100, 2, 0, 3, 4);
		run_table(32'h0000_0200, -1, 0, 3, 4);
		run_table(32'h0000_0300, 4, 0, 3, 4);
		run_table(32'h0000_0400, 0, 0, 3, 4);
		run_table(32'h0000_0500, 3, 0, 3, 4);
		run_table(32'h0000_0600, 5, 10, 9, 0);
		run_table(32'hffff_fff0, KeyMax, KeyMax, KeyMin, 0);
		run_table(32'hffff_fff0, KeyMin, KeyMin, KeyMin, 1);
		run_table(32'h0000_0000, KeyMax, KeyMax - 2, KeyMax, 3);
		run_table(32'h8000_0000, KeyMin, KeyMax - 1, KeyMax, 2);
		run_table(32'h7fff_ffff, KeyMax, KeyMin, KeyMin + 3, 4);
	endtask

	task automatic test_lookup_directed();
		int none[$];
		run_lookup(32'h0000_1000, 3, 0, none);
		run_lookup(32'h0000_1100, 3, 3, '{-5, 3, 9});
		run_lookup(32'h0000_1200, -5, 3, '{-5, 3, 9});
		run_lookup(32'h0000_1300, 9, 3, '{-5, 3, 9});
		run_lookup(32'h0000_1400, 4, 3, '{-5, 3, 9});
		run_lookup(32'h0000_1500, 100, 3, '{-5, 3, 9});
		run_lookup(32'hffff_ff00, KeyMin, 2, '{KeyMin, KeyMax});
		run_lookup(32'hffff_ff00, KeyMax, 2, '{KeyMin, KeyMax});
		run_lookup(32'h0000_1600, 7, 2, '{7, 7});
	endtask

	task automatic test_abandon_and_stray();
		send_word($urandom());
		send_word($urandom());
		run_table(32'h0000_4000, 5, KeyMin, KeyMax, 3);
		run_lookup(32'h0000_8000, 1, 32'hffff_ffff, '{0, 1});
		send_start(KIND_TABLE, $urandom(), 0);
		run_table(32'h0000_0040, 1, 0, 1, 2);
		send_word($urandom());
	endtask

	task automatic test_backpressure();
		int none[$];
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left <= HoldCycles;
		repeat (12) run_lookup($urandom(), $urandom(), 0, none);
	endtask

	task automatic test_random_mix(int idle_pct, int stall);
		int goal;
		goal = items_sent + 135;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		while (items_sent < goal)
			random_switch();
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t r;
		if (out_valid && out_ready) begin
			if (pending_targets.size() == 0) begin
				report_mismatch("result with nothing pending", target_address, '0);
			end else begin
				r = pending_targets.pop_front();
				targets_checked++;
				if (target_address !== r.target_address)
					report_mismatch("target_address", target_address, r.target_address);
				if (took_case !== r.took_case)
					report_mismatch("took_case", 32'(took_case), 32'(r.took_case));
			end
		end
	end

	always @(posedge clk) begin
		if (in_valid && !in_ready)
			input_stall_cycles++;
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("watchdog: no handshake for %0d cycles", QuietLimit);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_directed();
		test_lookup_directed();
		test_abandon_and_stray();
		test_backpressure();
		test_random_mix(0, 0);
		test_random_mix(52, 0);
		test_random_mix(0, 52);
		test_random_mix(22, 22);
		in_valid <= 1'b0;
		while (pending_targets.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("%0d requests over %0d table and lookup switches, incl. empty, abandoned, stray",
			items_sent, switches_started);
		$display("%0d branch targets checked, input held back %0d cycles",
			targets_checked, input_stall_cycles);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/swt_pkg.sv
rtl/swt_core.sv
rtl/swt_out.sv
rtl/switch_branch_target.sv
tb/tb_switch_branch_target.sv
